// File: rtl/core/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types and constants for the cubic Bezier evaluator: default
// parameters, register indexes, op codes, sequencer steps, control bundle.
// ----------------------------------------------------------------------------
package cbe_pkg;

   localparam int COORD_BITS_DEF = 21;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int OUT_W   = 21;  // width of every coordinate port
   localparam int T_W     = 17;  // Q0.16 with one representable
   localparam int CFG_W   = 63;
   localparam int CSR_IDX_W = 3;
   localparam int STEPS_W = 16;

   localparam logic [T_W-1:0] STEP_SIZE_RESET = 17'd655;
   localparam logic [T_W-1:0] T_ONE           = 17'd65536;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_POINT0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POINT1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POINT2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POINT3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP   = 3'd4;

   // op codes; 0 and 3 evaluate only
   localparam logic [1:0] OP_TRACK       = 2'd1;
   localparam logic [1:0] OP_CLEAR_TRACK = 2'd2;

   // sequencer steps (one multiplier issue per step)
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] SQ_T        = 5'd0;   // steps * step_size
   localparam logic [STEP_W-1:0] SQ_TT       = 5'd2;   // t * t
   localparam logic [STEP_W-1:0] SQ_UU       = 5'd3;   // u * u
   localparam logic [STEP_W-1:0] SQ_TU       = 5'd4;   // t^2 * u
   localparam logic [STEP_W-1:0] SQ_TTT      = 5'd5;   // t^2 * t
   localparam logic [STEP_W-1:0] SQ_UUU      = 5'd6;   // u^2 * u
   localparam logic [STEP_W-1:0] SQ_UUT      = 5'd7;   // u^2 * t
   localparam logic [STEP_W-1:0] SQ_MAC0     = 5'd8;   // first coord * weight
   localparam logic [STEP_W-1:0] SQ_MAC_LAST = 5'd19;
   localparam logic [STEP_W-1:0] SQ_LAST     = 5'd20;  // drains last product

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } seq_state_type;

   typedef struct packed {
      logic              start;
      logic              issue;
      logic [STEP_W-1:0] step;
      logic              wb_valid;
      logic [STEP_W-1:0] wb_tag;
      logic              load;
   } seq_ctl_type;

endpackage

// File: rtl/core/cbe_seq.sv
// ----------------------------------------------------------------------------
// cbe_seq
// Step sequencer for the shared multiplier: request handshake, step
// counter, write-back tags and the result register handshake.
// ----------------------------------------------------------------------------
module cbe_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cbe_pkg::seq_ctl_type ctl
);

   cbe_pkg::seq_state_type state_ff, state_in;
   logic [cbe_pkg::STEP_W-1:0] step_ff, step_in;
   logic [cbe_pkg::STEP_W-1:0] wb_tag_ff;
   logic                       wb_valid_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         cbe_pkg::ST_IDLE: begin
            step_in = cbe_pkg::SQ_T;
            if (req_valid) begin
               state_in = cbe_pkg::ST_RUN;
            end
         end
         cbe_pkg::ST_RUN: begin
            step_in = step_ff + cbe_pkg::STEP_W'(1);
            if (step_ff == cbe_pkg::SQ_LAST) begin
               state_in = cbe_pkg::ST_FIN;
            end
         end
         cbe_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = cbe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cbe_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctl.start    = 1'b0;
      ctl.issue    = 1'b0;
      ctl.load     = 1'b0;
      ctl.step     = step_ff;
      ctl.wb_valid = wb_valid_ff;
      ctl.wb_tag   = wb_tag_ff;
      req_stall    = 1'b1;
      unique case (state_ff)
         cbe_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ctl.start = req_valid;
         end
         cbe_pkg::ST_RUN: begin
            ctl.issue = 1'b1;
         end
         cbe_pkg::ST_FIN: begin
            ctl.load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = ctl.load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbe_pkg::ST_IDLE;
         step_ff      <= cbe_pkg::SQ_T;
         wb_valid_ff  <= 1'b0;
         wb_tag_ff    <= cbe_pkg::SQ_T;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         wb_valid_ff  <= ctl.issue;
         wb_tag_ff    <= step_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/cubic_bezier_eval_max_height.sv
// ----------------------------------------------------------------------------
// cubic_bezier_eval_max_height
// Cubic Bezier point evaluation from four configured control points, with
// tracking of the highest (greatest y) sample.
// ----------------------------------------------------------------------------
// One request is taken at a time; the next is accepted once the sequencer
// has loaded the result register and returned to idle, which waits while a
// held result is stalled. The sequence is set by the single signed multiplier:
// 19 products (t, four Bernstein weights from t^2 and (1-t)^2, then 12
// coordinate times weight terms accumulated axis by axis), a bubble while t is
// written back, a step to drain the last product, a step to update the peak
// and load the result register, and an idle state to take the next request.
// The result register lets a finished result wait while the next request is
// accepted. Configuration writes are always ready and must only be made while
// no request is in flight.
module cubic_bezier_eval_max_height #(
   parameter int COORD_BITS = cbe_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = cbe_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [cbe_pkg::STEPS_W-1:0]       req_steps,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [cbe_pkg::OUT_W-1:0]  rsp_pos_x,
   output logic signed [cbe_pkg::OUT_W-1:0]  rsp_pos_y,
   output logic signed [cbe_pkg::OUT_W-1:0]  rsp_pos_z,
   output logic signed [cbe_pkg::OUT_W-1:0]  rsp_peak_x,
   output logic signed [cbe_pkg::OUT_W-1:0]  rsp_peak_y,
   output logic signed [cbe_pkg::OUT_W-1:0]  rsp_peak_z,
   output logic [cbe_pkg::T_W-1:0]           rsp_peak_t,
   output logic                              rsp_new_peak,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cbe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cbe_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int PT_W  = 3 * COORD_BITS;
   localparam int FW    = FRAC_BITS + 1;        // t, u, t^2, u^2
   localparam int WW    = FRAC_BITS + 3;        // weights, up to three
   localparam int OPW_A = (COORD_BITS > 18) ? COORD_BITS : 18;
   localparam int OPW   = (OPW_A > FRAC_BITS + 4) ? OPW_A : FRAC_BITS + 4;
   localparam int PW    = 2 * OPW;
   localparam int ACC_W = PW + 1;
   localparam int TSH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int TSH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int TX_W  = FRAC_BITS + 18;

   localparam logic [PW-1:0] P_HALF = PW'(1) << (FRAC_BITS - 1);
   localparam logic [FW-1:0] F_ONE  = FW'(1) << FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] ACC_CMAX = ACC_W'((1 << (COORD_BITS - 1)) - 1);
   localparam logic signed [ACC_W-1:0] ACC_CMIN = ACC_W'(-(1 << (COORD_BITS - 1)));
   localparam logic signed [COORD_BITS-1:0] C_MIN = ACC_CMIN[COORD_BITS-1:0];
   localparam logic [1:0] LAST_TERM = 2'd3;

   cbe_pkg::seq_ctl_type ctl;

   cbe_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   // configuration
   logic [PT_W-1:0]           pt_ff [4];
   logic [cbe_pkg::T_W-1:0]   step_size_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            pt_ff[i] <= '0;
         end
         step_size_ff <= cbe_pkg::STEP_SIZE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            cbe_pkg::REG_POINT0: pt_ff[0] <= csr_wdata[PT_W-1:0];
            cbe_pkg::REG_POINT1: pt_ff[1] <= csr_wdata[PT_W-1:0];
            cbe_pkg::REG_POINT2: pt_ff[2] <= csr_wdata[PT_W-1:0];
            cbe_pkg::REG_POINT3: pt_ff[3] <= csr_wdata[PT_W-1:0];
            cbe_pkg::REG_STEP:   step_size_ff <= csr_wdata[cbe_pkg::T_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // request capture
   logic [1:0]                   op_ff;
   logic [cbe_pkg::STEPS_W-1:0]  steps_ff;

   // datapath registers
   logic [cbe_pkg::T_W-1:0]      t16_ff, t16_in;
   logic [FW-1:0]                tf_ff, tf_in, u_ff, u_in;
   logic [FW-1:0]                t2_ff, t2_in, u2_ff, u2_in;
   logic [WW-1:0]                w_ff [4];
   logic [WW-1:0]                w_in [4];
   logic signed [PW-1:0]         prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [COORD_BITS-1:0] pos_ff [3];
   logic signed [COORD_BITS-1:0] pos_in [3];

   // operand select for the shared multiplier
   logic signed [OPW-1:0]        opa, opb;
   logic signed [COORD_BITS-1:0] crd;
   logic [cbe_pkg::STEP_W-1:0]   midx;
   logic [1:0]                   maxis, mterm;
   logic                         is_mac;

   assign is_mac = (ctl.step >= cbe_pkg::SQ_MAC0) && (ctl.step <= cbe_pkg::SQ_MAC_LAST);
   assign midx   = ctl.step - cbe_pkg::SQ_MAC0;
   assign maxis  = midx[3:2];
   assign mterm  = midx[1:0];
   assign crd    = pt_ff[mterm][32'(maxis) * COORD_BITS +: COORD_BITS];

   always_comb begin
      opa = '0;
      opb = '0;
      if (ctl.issue) begin
         if (is_mac) begin
            opa = OPW'(crd);
            opb = OPW'(w_ff[mterm]);
         end else begin
            case (ctl.step)
               cbe_pkg::SQ_T: begin
                  opa = OPW'(steps_ff);
                  opb = OPW'(step_size_ff);
               end
               cbe_pkg::SQ_TT: begin
                  opa = OPW'(tf_ff);
                  opb = OPW'(tf_ff);
               end
               cbe_pkg::SQ_UU: begin
                  opa = OPW'(u_ff);
                  opb = OPW'(u_ff);
               end
               cbe_pkg::SQ_TU: begin
                  opa = OPW'(t2_ff);
                  opb = OPW'(u_ff);
               end
               cbe_pkg::SQ_TTT: begin
                  opa = OPW'(t2_ff);
                  opb = OPW'(tf_ff);
               end
               cbe_pkg::SQ_UUU: begin
                  opa = OPW'(u2_ff);
                  opb = OPW'(u_ff);
               end
               cbe_pkg::SQ_UUT: begin
                  opa = OPW'(u2_ff);
                  opb = OPW'(tf_ff);
               end
               default: begin
                  opa = '0;
                  opb = '0;
               end
            endcase
         end
      end
   end

   assign prod_in = opa * opb;

   // write-back of the previous cycle's product
   logic [PW-1:0]              rnd_full;
   logic [FW-1:0]              rnd_v;
   logic [WW-1:0]              rnd_w, rnd_w3;
   logic [TX_W-1:0]            t_ext;
   logic signed [ACC_W-1:0]    acc_sum, acc_sh;
   logic [cbe_pkg::STEP_W-1:0] widx;
   logic [1:0]                 waxis, wterm;
   logic                       wb_mac;

   assign rnd_full = prod_ff + P_HALF;
   assign rnd_v    = rnd_full[FRAC_BITS +: FW];
   assign rnd_w    = WW'(rnd_v);
   assign rnd_w3   = rnd_w + (rnd_w << 1);
   assign t_ext    = (TX_W'(t16_in) << TSH_L) >> TSH_R;
   assign acc_sum  = acc_ff + ACC_W'(prod_ff);
   assign acc_sh   = acc_sum >>> FRAC_BITS;
   assign wb_mac   = (ctl.wb_tag >= cbe_pkg::SQ_MAC0) && (ctl.wb_tag <= cbe_pkg::SQ_MAC_LAST);
   assign widx     = ctl.wb_tag - cbe_pkg::SQ_MAC0;
   assign waxis    = widx[3:2];
   assign wterm    = widx[1:0];

   always_comb begin
      t16_in = t16_ff;
      tf_in  = tf_ff;
      u_in   = u_ff;
      t2_in  = t2_ff;
      u2_in  = u2_ff;
      acc_in = acc_ff;
      for (int i = 0; i < 4; i++) begin
         w_in[i] = w_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         pos_in[i] = pos_ff[i];
      end
      if (prod_ff[PW-1:6] > (PW-6)'(cbe_pkg::T_ONE)) begin
         t16_in = cbe_pkg::T_ONE;
      end else begin
         t16_in = prod_ff[6 +: cbe_pkg::T_W];
      end
      if (ctl.wb_tag != cbe_pkg::SQ_T || !ctl.wb_valid) begin
         t16_in = t16_ff;
      end
      if (ctl.start) begin
         acc_in = ACC_HALF;
      end else if (ctl.wb_valid) begin
         if (wb_mac) begin
            if (wterm == LAST_TERM) begin
               acc_in = ACC_HALF;
               if (acc_sh > ACC_CMAX) begin
                  pos_in[waxis] = ACC_CMAX[COORD_BITS-1:0];
               end else if (acc_sh < ACC_CMIN) begin
                  pos_in[waxis] = C_MIN;
               end else begin
                  pos_in[waxis] = acc_sh[COORD_BITS-1:0];
               end
            end else begin
               acc_in = acc_sum;
            end
         end else begin
            case (ctl.wb_tag)
               cbe_pkg::SQ_T: begin
                  tf_in = t_ext[FW-1:0];
                  u_in  = F_ONE - t_ext[FW-1:0];
               end
               cbe_pkg::SQ_TT:  t2_in   = rnd_v;
               cbe_pkg::SQ_UU:  u2_in   = rnd_v;
               cbe_pkg::SQ_TU:  w_in[2] = rnd_w3;
               cbe_pkg::SQ_TTT: w_in[3] = rnd_w;
               cbe_pkg::SQ_UUU: w_in[0] = rnd_w;
               cbe_pkg::SQ_UUT: w_in[1] = rnd_w3;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         op_ff    <= req_op;
         steps_ff <= req_steps;
      end
      prod_ff <= prod_in;
      t16_ff  <= t16_in;
      tf_ff   <= tf_in;
      u_ff    <= u_in;
      t2_ff   <= t2_in;
      u2_ff   <= u2_in;
      acc_ff  <= acc_in;
      for (int i = 0; i < 4; i++) begin
         w_ff[i] <= w_in[i];
      end
      for (int i = 0; i < 3; i++) begin
         pos_ff[i] <= pos_in[i];
      end
   end

   // peak tracking, committed when the result is loaded
   logic signed [COORD_BITS-1:0] best_x_ff, best_y_ff, best_z_ff;
   logic signed [COORD_BITS-1:0] best_x_in, best_y_in, best_z_in;
   logic signed [COORD_BITS-1:0] base_x, base_y, base_z;
   logic [cbe_pkg::T_W-1:0]      best_t_ff, best_t_in, base_t;
   logic                         track, clear, fresh;

   assign clear = (op_ff == cbe_pkg::OP_CLEAR_TRACK);
   assign track = (op_ff == cbe_pkg::OP_TRACK) || clear;

   always_comb begin
      base_x = clear ? '0 : best_x_ff;
      base_y = clear ? C_MIN : best_y_ff;
      base_z = clear ? '0 : best_z_ff;
      base_t = clear ? '0 : best_t_ff;
      fresh  = track && (pos_ff[1] > base_y);
      best_x_in = fresh ? pos_ff[0] : base_x;
      best_y_in = fresh ? pos_ff[1] : base_y;
      best_z_in = fresh ? pos_ff[2] : base_z;
      best_t_in = fresh ? t16_ff : base_t;
      if (!track) begin
         best_x_in = best_x_ff;
         best_y_in = best_y_ff;
         best_z_in = best_z_ff;
         best_t_in = best_t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_x_ff <= '0;
         best_y_ff <= C_MIN;
         best_z_ff <= '0;
         best_t_ff <= '0;
      end else if (ctl.load) begin
         best_x_ff <= best_x_in;
         best_y_ff <= best_y_in;
         best_z_ff <= best_z_in;
         best_t_ff <= best_t_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rsp_pos_x    <= (cbe_pkg::OUT_W)'(pos_ff[0]);
         rsp_pos_y    <= (cbe_pkg::OUT_W)'(pos_ff[1]);
         rsp_pos_z    <= (cbe_pkg::OUT_W)'(pos_ff[2]);
         rsp_peak_x   <= (cbe_pkg::OUT_W)'(best_x_in);
         rsp_peak_y   <= (cbe_pkg::OUT_W)'(best_y_in);
         rsp_peak_z   <= (cbe_pkg::OUT_W)'(best_z_in);
         rsp_peak_t   <= best_t_in;
         rsp_new_peak <= fresh;
      end
   end

endmodule

// File: rtl/core/cbe_checker.sv
// ----------------------------------------------------------------------------
// cbe_checker
// Port-level checks for the Bezier evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module cbe_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [cbe_pkg::OUT_W-1:0]  rsp_pos_x,
   input logic signed [cbe_pkg::OUT_W-1:0]  rsp_pos_y,
   input logic signed [cbe_pkg::OUT_W-1:0]  rsp_pos_z,
   input logic signed [cbe_pkg::OUT_W-1:0]  rsp_peak_x,
   input logic signed [cbe_pkg::OUT_W-1:0]  rsp_peak_y,
   input logic signed [cbe_pkg::OUT_W-1:0]  rsp_peak_z,
   input logic                              rsp_new_peak
);

   // an accepted request holds off the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one in flight");

   // a fresh result only comes out of a request in progress
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no request in progress");

   // a new peak is the sample just evaluated
   a_new_peak_is_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_peak |->
         rsp_peak_x == rsp_pos_x && rsp_peak_y == rsp_pos_y && rsp_peak_z == rsp_pos_z)
      else $error("new peak differs from evaluated point");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_y) && $stable(rsp_peak_y))
      else $error("stalled result changed");

endmodule

bind cubic_bezier_eval_max_height cbe_checker u_cbe_checker (.*);
